// ===== rtl/core/sri_pkg.sv =====
package sri_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int C2_W      = 2 * COORD_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int NUM_EDGES = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = CFG_IDX_W'(3);

    localparam int EDGE_TOP    = 0;
    localparam int EDGE_RIGHT  = 1;
    localparam int EDGE_BOTTOM = 2;
    localparam int EDGE_LEFT   = 3;

    localparam logic [NUM_EDGES-1:0] EDGE_HORIZ = NUM_EDGES'(4'b0101);

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_seg_in;

    typedef struct packed {
        logic                 hit;
        logic [NUM_EDGES-1:0] edge_hits;
    } t_seg_out;

endpackage

// ===== rtl/core/segment_rectangle_intersect_unit.sv =====
// Segment versus rectangle edge test, four register stages.
// Segments pass in order through the difference, product, sum and mask registers.
// Throughput: one segment per cycle unless stalled; per-edge multiply stage sets the clock.
// A stage advances when empty or when the next stage advances, so bubbles collapse.
// Reset (synchronous, active low) empties the pipeline and clears the rectangle to zero.
module segment_rectangle_intersect_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  sri_pkg::t_seg_in                  i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output sri_pkg::t_seg_out                 o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sri_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  sri_pkg::t_coord                   i_cfg_data
);
    import sri_pkg::*;

    t_coord r_left, r_top, r_right, r_bottom;

    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    logic signed [DIFF_W-1:0] n_dv  [NUM_EDGES];
    logic signed [DIFF_W-1:0] n_du  [NUM_EDGES];
    logic signed [DIFF_W-1:0] n_dal [NUM_EDGES];
    logic signed [DIFF_W-1:0] n_ua  [NUM_EDGES];
    logic signed [DIFF_W-1:0] n_vy  [NUM_EDGES];
    t_coord                   n_y   [NUM_EDGES];

    logic signed [DIFF_W-1:0] r_s1_dv  [NUM_EDGES];
    logic signed [DIFF_W-1:0] r_s1_du  [NUM_EDGES];
    logic signed [DIFF_W-1:0] r_s1_dal [NUM_EDGES];
    logic signed [DIFF_W-1:0] r_s1_ua  [NUM_EDGES];
    logic signed [DIFF_W-1:0] r_s1_vy  [NUM_EDGES];
    t_coord                   r_s1_y   [NUM_EDGES];
    t_seg_in                  r_s1_seg;

    logic signed [PROD_W-1:0] r_s2_pd   [NUM_EDGES];
    logic signed [PROD_W-1:0] r_s2_pna1 [NUM_EDGES];
    logic signed [PROD_W-1:0] r_s2_pna2 [NUM_EDGES];
    logic signed [PROD_W-1:0] r_s2_pnb  [NUM_EDGES];
    logic signed [PROD_W-1:0] r_s2_pc   [NUM_EDGES];
    logic [NUM_EDGES-1:0]     r_s2_eqa;
    logic [NUM_EDGES-1:0]     r_s2_gate;
    logic signed [C2_W-1:0]   r_s2_c2a;
    logic signed [C2_W-1:0]   r_s2_c2b;

    logic signed [PROD_W-1:0] r_s3_d   [NUM_EDGES];
    logic signed [SUM_W-1:0]  r_s3_na  [NUM_EDGES];
    logic signed [PROD_W-1:0] r_s3_nb  [NUM_EDGES];
    logic signed [SUM_W-1:0]  r_s3_col [NUM_EDGES];
    logic [NUM_EDGES-1:0]     r_s3_eqa;
    logic [NUM_EDGES-1:0]     r_s3_gate;

    logic [NUM_EDGES-1:0]     n_mask;
    t_seg_out                 r_out;

    function automatic logic ratio_ok(input logic signed [SUM_W-1:0] n,
                                      input logic signed [SUM_W-1:0] d);
        logic ok;
        if (d < 0) begin
            ok = (d <= n) && (n <= 0);
        end else begin
            ok = (n >= 0) && (n <= d);
        end
        return ok;
    endfunction

    assign en4        = !r_v4 || !i_out_stall;
    assign en3        = !r_v3 || en4;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_stall = !en1;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_v4;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LEFT:   r_left   <= i_cfg_data;
                REG_TOP:    r_top    <= i_cfg_data;
                REG_RIGHT:  r_right  <= i_cfg_data;
                REG_BOTTOM: r_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Vertical edges are tested with x and y swapped, which negates d, na and nb alike.
    always_comb begin
        t_coord u3, v3, u4, v4, a1, a2, yc;
        for (int e = 0; e < NUM_EDGES; e++) begin
            if (EDGE_HORIZ[e]) begin
                u3 = i_in_data.start_x;
                v3 = i_in_data.start_y;
                u4 = i_in_data.end_x;
                v4 = i_in_data.end_y;
            end else begin
                u3 = i_in_data.start_y;
                v3 = i_in_data.start_x;
                u4 = i_in_data.end_y;
                v4 = i_in_data.end_x;
            end
            case (e)
                EDGE_TOP: begin
                    a1 = r_left;
                    a2 = r_right;
                    yc = r_top;
                end
                EDGE_BOTTOM: begin
                    a1 = r_left;
                    a2 = r_right;
                    yc = r_bottom;
                end
                EDGE_RIGHT: begin
                    a1 = r_top;
                    a2 = r_bottom;
                    yc = r_right;
                end
                EDGE_LEFT: begin
                    a1 = r_top;
                    a2 = r_bottom;
                    yc = r_left;
                end
                default: begin
                    a1 = '0;
                    a2 = '0;
                    yc = '0;
                end
            endcase
            n_dv[e]  = DIFF_W'(v4) - DIFF_W'(v3);
            n_du[e]  = DIFF_W'(u4) - DIFF_W'(u3);
            n_dal[e] = DIFF_W'(a1) - DIFF_W'(a2);
            n_ua[e]  = DIFF_W'(u4) - DIFF_W'(a2);
            n_vy[e]  = DIFF_W'(v4) - DIFF_W'(yc);
            n_y[e]   = yc;
        end
    end

    always_comb begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            if (r_s3_d[e] == '0) begin
                n_mask[e] = r_s3_eqa[e] || (r_s3_gate[e] && (r_s3_col[e] == '0));
            end else begin
                n_mask[e] = ratio_ok(r_s3_na[e], SUM_W'(r_s3_d[e]))
                         && ratio_ok(SUM_W'(r_s3_nb[e]), SUM_W'(r_s3_d[e]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_seg <= i_in_data;
            for (int e = 0; e < NUM_EDGES; e++) begin
                r_s1_dv[e]  <= n_dv[e];
                r_s1_du[e]  <= n_du[e];
                r_s1_dal[e] <= n_dal[e];
                r_s1_ua[e]  <= n_ua[e];
                r_s1_vy[e]  <= n_vy[e];
                r_s1_y[e]   <= n_y[e];
            end
        end
        if (en2) begin
            r_s2_c2a <= C2_W'(r_s1_seg.start_x) * C2_W'(r_s1_seg.end_y);
            r_s2_c2b <= C2_W'(r_s1_seg.end_x) * C2_W'(r_s1_seg.start_y);
            for (int e = 0; e < NUM_EDGES; e++) begin
                r_s2_pd[e]   <= PROD_W'(r_s1_dv[e]) * PROD_W'(r_s1_dal[e]);
                r_s2_pna1[e] <= PROD_W'(r_s1_ua[e]) * PROD_W'(r_s1_dv[e]);
                r_s2_pna2[e] <= PROD_W'(r_s1_du[e]) * PROD_W'(r_s1_vy[e]);
                r_s2_pnb[e]  <= PROD_W'(r_s1_dal[e]) * PROD_W'(r_s1_vy[e]);
                r_s2_pc[e]   <= PROD_W'(r_s1_y[e]) * PROD_W'(r_s1_du[e]);
                r_s2_eqa[e]  <= (r_s1_dal[e] == '0);
                r_s2_gate[e] <= (r_s1_y[e] == '0) || (r_s1_dv[e] == '0);
            end
        end
        if (en3) begin
            for (int e = 0; e < NUM_EDGES; e++) begin
                r_s3_d[e]    <= r_s2_pd[e];
                r_s3_na[e]   <= SUM_W'(r_s2_pna1[e]) - SUM_W'(r_s2_pna2[e]);
                r_s3_nb[e]   <= r_s2_pnb[e];
                r_s3_eqa[e]  <= r_s2_eqa[e];
                r_s3_gate[e] <= r_s2_gate[e];
                if (EDGE_HORIZ[e]) begin
                    r_s3_col[e] <= SUM_W'(r_s2_pc[e]) + SUM_W'(r_s2_c2a)
                                 - SUM_W'(r_s2_c2b);
                end else begin
                    r_s3_col[e] <= SUM_W'(r_s2_pc[e]) - SUM_W'(r_s2_c2a)
                                 + SUM_W'(r_s2_c2b);
                end
            end
        end
        if (en4) begin
            r_out.hit       <= |n_mask;
            r_out.edge_hits <= n_mask;
        end
    end

`ifndef SYNTHESIS
    a_hit_is_or: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.hit == (|o_out_data.edge_hits)))
        else $error("hit flag disagrees with edge mask");

    a_full_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && i_out_stall) |-> o_in_stall)
        else $error("input taken while pipeline full and stalled");

    a_transfer_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("input transfer lost at first stage");
`endif

endmodule
